/* hdl/sdmd_pkg.sv */
// Shared types, widths and register codes of the sigma-delta motion detector.
// Used by every module under hdl; depends on nothing.
package sdmd_pkg;

    localparam int PIX_W    = 8;
    localparam int INDEX_W  = 16;
    localparam int AMP_W    = 4;
    localparam int VAR_W    = 8;
    localparam int TARGET_W = AMP_W + PIX_W;
    localparam int WORD_W   = PIX_W + VAR_W;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [AMP_W-1:0] AMP_RESET     = 4'd2;
    localparam logic [VAR_W-1:0] VAR_MIN_RESET = 8'd1;
    localparam logic [VAR_W-1:0] VAR_MAX_RESET = 8'd254;

    typedef enum logic [1:0] {
        REG_AMPLIFICATION = 2'd0,
        REG_VARIANCE_MIN  = 2'd1,
        REG_VARIANCE_MAX  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [AMP_W-1:0] amplification;
        logic [VAR_W-1:0] variance_min;
        logic [VAR_W-1:0] variance_max;
    } cfg_t;

    // One frame-store entry: background estimate and variance of a pixel.
    typedef struct packed {
        logic [PIX_W-1:0] background;
        logic [VAR_W-1:0] variance;
    } store_word_t;

endpackage

/* hdl/sdmd_regs.sv */
// Configuration register file with an APB-style slave port.
// Depends on sdmd_pkg for the register codes, reset values and cfg_t.
module sdmd_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdmd_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdmd_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdmd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output sdmd_pkg::cfg_t                cfg
);

    sdmd_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplification <= sdmd_pkg::AMP_RESET;
            cfg_reg.variance_min  <= sdmd_pkg::VAR_MIN_RESET;
            cfg_reg.variance_max  <= sdmd_pkg::VAR_MAX_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                sdmd_pkg::REG_AMPLIFICATION:
                    cfg_reg.amplification <= pwdata[sdmd_pkg::AMP_W-1:0];
                sdmd_pkg::REG_VARIANCE_MIN:
                    cfg_reg.variance_min <= pwdata[sdmd_pkg::VAR_W-1:0];
                sdmd_pkg::REG_VARIANCE_MAX:
                    cfg_reg.variance_max <= pwdata[sdmd_pkg::VAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            sdmd_pkg::REG_AMPLIFICATION:
                prdata = sdmd_pkg::PDATA_W'(cfg_reg.amplification);
            sdmd_pkg::REG_VARIANCE_MIN:
                prdata = sdmd_pkg::PDATA_W'(cfg_reg.variance_min);
            sdmd_pkg::REG_VARIANCE_MAX:
                prdata = sdmd_pkg::PDATA_W'(cfg_reg.variance_max);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* hdl/sdmd_store.sv */
// Frame store holding background and variance of every pixel in one memory.
// One write port and one read port with registered read data; uses sdmd_pkg.
module sdmd_store
(
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [sdmd_pkg::INDEX_W-1:0]  rd_addr,
    output sdmd_pkg::store_word_t         rd_data,
    input  logic                          wr_en,
    input  logic [sdmd_pkg::INDEX_W-1:0]  wr_addr,
    input  sdmd_pkg::store_word_t         wr_data
);

    localparam int DEPTH = 1 << sdmd_pkg::INDEX_W;

    sdmd_pkg::store_word_t mem [DEPTH];
    sdmd_pkg::store_word_t rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read at the same edge as a write to that entry returns the old word;
    // the pipeline forwards around it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

/* hdl/sdmd_update.sv */
// Per-pixel sigma-delta update: background step, absolute difference,
// variance step toward the amplified difference, clamp and decision. Uses sdmd_pkg.
module sdmd_update
(
    input  logic [sdmd_pkg::PIX_W-1:0]  pixel_value,
    input  logic                        first_frame,
    input  sdmd_pkg::store_word_t       old_word,
    input  sdmd_pkg::cfg_t              cfg,
    output sdmd_pkg::store_word_t       new_word,
    output logic [sdmd_pkg::PIX_W-1:0]  abs_difference,
    output logic                        foreground
);

    logic [sdmd_pkg::PIX_W-1:0]    bg_old;
    logic [sdmd_pkg::PIX_W-1:0]    bg_new;
    logic [sdmd_pkg::VAR_W-1:0]    var_old;
    logic [sdmd_pkg::TARGET_W-1:0] target;
    logic [sdmd_pkg::TARGET_W-1:0] var_old_ext;
    logic [sdmd_pkg::VAR_W:0]      var_step;
    logic [sdmd_pkg::VAR_W:0]      var_hi;
    logic [sdmd_pkg::VAR_W:0]      var_lo;
    logic [sdmd_pkg::PIX_W-1:0]    diff;

    always_comb
    begin
        // A first-frame pixel starts from its own value and the minimum variance.
        bg_old  = first_frame ? pixel_value : old_word.background;
        var_old = first_frame ? cfg.variance_min : old_word.variance;

        if (bg_old < pixel_value)
        begin
            bg_new = bg_old + 1'b1;
        end
        else if (bg_old > pixel_value)
        begin
            bg_new = bg_old - 1'b1;
        end
        else
        begin
            bg_new = bg_old;
        end

        diff = (bg_new >= pixel_value) ? (bg_new - pixel_value) : (pixel_value - bg_new);

        target      = sdmd_pkg::TARGET_W'(cfg.amplification)
                      * sdmd_pkg::TARGET_W'(diff);
        var_old_ext = sdmd_pkg::TARGET_W'(var_old);

        // The step is one bit wider so that 255 stepping up clamps instead of wrapping.
        if (var_old_ext < target)
        begin
            var_step = {1'b0, var_old} + 1'b1;
        end
        else if (var_old_ext > target)
        begin
            var_step = {1'b0, var_old} - 1'b1;
        end
        else
        begin
            var_step = {1'b0, var_old};
        end

        var_hi = (var_step > {1'b0, cfg.variance_max}) ? {1'b0, cfg.variance_max} : var_step;
        var_lo = (var_hi < {1'b0, cfg.variance_min}) ? {1'b0, cfg.variance_min} : var_hi;

        new_word.background = bg_new;
        new_word.variance   = var_lo[sdmd_pkg::VAR_W-1:0];
        abs_difference      = diff;
        foreground          = (diff >= var_lo[sdmd_pkg::VAR_W-1:0]);
    end

endmodule

/* hdl/sigma_delta_motion_detect.sv */
// Sigma-delta motion detector, one pixel per cycle sustained while results are taken.
// A pixel's store read and stage registers load at its input transfer; its update goes
// into the result register when that register is empty or drains, so the output can
// stall it. Throughput is one pixel per clock while results are taken, set by the single
// read-modify-write pass through the frame store. Reset clears the pipeline
// valids and loads the configuration defaults; the frame store is not cleared.
module sigma_delta_motion_detect
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdmd_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdmd_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdmd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic [sdmd_pkg::PIX_W-1:0]    pixel_value,
    input  logic [sdmd_pkg::INDEX_W-1:0]  pixel_index,
    input  logic                          first_frame,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          foreground,
    output logic [sdmd_pkg::PIX_W-1:0]    abs_difference,
    output logic [sdmd_pkg::VAR_W-1:0]    variance_out
);

    sdmd_pkg::cfg_t        cfg;
    sdmd_pkg::store_word_t rd_word;
    sdmd_pkg::store_word_t old_word;
    sdmd_pkg::store_word_t new_word;

    logic                          s1_valid_reg;
    logic [sdmd_pkg::PIX_W-1:0]    s1_pix_reg;
    logic [sdmd_pkg::INDEX_W-1:0]  s1_addr_reg;
    logic                          s1_first_reg;
    logic                          fwd_hit_reg;
    sdmd_pkg::store_word_t         fwd_word_reg;

    logic                          out_valid_reg;
    logic                          out_fg_reg;
    logic [sdmd_pkg::PIX_W-1:0]    out_diff_reg;
    logic [sdmd_pkg::VAR_W-1:0]    out_var_reg;

    logic                          s1_adv;
    logic                          accept;
    logic                          upd_fg;
    logic [sdmd_pkg::PIX_W-1:0]    upd_diff;

    sdmd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The update stage moves on when the result register is empty or drains.
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || result_ready);
    assign pixel_ready = !s1_valid_reg || s1_adv;
    assign accept      = pixel_valid && pixel_ready;

    sdmd_store u_store
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pixel_index),
        .rd_data (rd_word),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (new_word)
    );

    // The write of the item ahead lands at the same edge as this item's read.
    assign old_word = fwd_hit_reg ? fwd_word_reg : rd_word;

    sdmd_update u_update
    (
        .pixel_value    (s1_pix_reg),
        .first_frame    (s1_first_reg),
        .old_word       (old_word),
        .cfg            (cfg),
        .new_word       (new_word),
        .abs_difference (upd_diff),
        .foreground     (upd_fg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_adv && (s1_addr_reg == pixel_index);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel_value;
            s1_addr_reg  <= pixel_index;
            s1_first_reg <= first_frame;
            fwd_word_reg <= new_word;
        end
        if (s1_adv)
        begin
            out_fg_reg   <= upd_fg;
            out_diff_reg <= upd_diff;
            out_var_reg  <= new_word.variance;
        end
    end

    assign result_valid   = out_valid_reg;
    assign foreground     = out_fg_reg;
    assign abs_difference = out_diff_reg;
    assign variance_out   = out_var_reg;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sigma-delta motion detector.
// Depends on sdmd_pkg and sigma_delta_motion_detect under hdl; reads no files.

module testbench;

    localparam int POOL_SIZE      = 8;
    localparam int PHASE_ITEMS    = 165;
    localparam int RANDOM_PHASES  = 8;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic                       foreground;
        logic [sdmd_pkg::PIX_W-1:0] abs_difference;
        logic [sdmd_pkg::VAR_W-1:0] variance;
    } motion_verdict_t;

    typedef struct {
        logic [sdmd_pkg::PIX_W-1:0]   value;
        logic [sdmd_pkg::INDEX_W-1:0] index;
        logic                         first;
    } pixel_item_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sdmd_pkg::PADDR_W-1:0]   paddr;
    logic [sdmd_pkg::PDATA_W-1:0]   pwdata;
    logic [sdmd_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           pixel_valid;
    logic                           pixel_ready;
    logic [sdmd_pkg::PIX_W-1:0]     pixel_value;
    logic [sdmd_pkg::INDEX_W-1:0]   pixel_index;
    logic                           first_frame;
    logic                           result_valid;
    logic                           result_ready;
    logic                           foreground;
    logic [sdmd_pkg::PIX_W-1:0]     abs_difference;
    logic [sdmd_pkg::VAR_W-1:0]     variance_out;

    // Predictor state: per-pixel background and variance, plus register copies.
    logic [sdmd_pkg::PIX_W-1:0]     background_est [65536];
    logic [sdmd_pkg::VAR_W-1:0]     variance_est [65536];
    logic [sdmd_pkg::AMP_W-1:0]     amp_cfg  = sdmd_pkg::AMP_RESET;
    logic [sdmd_pkg::VAR_W-1:0]     vmin_cfg = sdmd_pkg::VAR_MIN_RESET;
    logic [sdmd_pkg::VAR_W-1:0]     vmax_cfg = sdmd_pkg::VAR_MAX_RESET;

    pixel_item_t                    pixel_queue [$];
    motion_verdict_t                expected_verdicts [$];
    motion_verdict_t                oldest_verdict;
    int unsigned                    pixels_in_flight = 0;
    int unsigned                    mismatch_count = 0;

    // Stimulus bookkeeping at generation time.
    bit                             index_loaded [65536];
    logic [sdmd_pkg::INDEX_W-1:0]   loaded_list [$];
    logic [sdmd_pkg::INDEX_W-1:0]   hot_index [POOL_SIZE];
    int                             scene_level [POOL_SIZE];

    bit                             idle_on = 1'b0;
    bit                             hold_result = 1'b0;
    bit                             hold_trigger = 1'b0;
    bit                             pixel_sent = 1'b0;
    int unsigned                    send_gap = 0;
    int unsigned                    ready_gap = 0;

    sigma_delta_motion_detect uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel_value    (pixel_value),
        .pixel_index    (pixel_index),
        .first_frame    (first_frame),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .foreground     (foreground),
        .abs_difference (abs_difference),
        .variance_out   (variance_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // One sigma-delta update of a pixel, applied to the predictor's own stores.
    function automatic motion_verdict_t update_motion(
        input logic [sdmd_pkg::PIX_W-1:0]   pix,
        input logic [sdmd_pkg::INDEX_W-1:0] idx,
        input logic                         first);
        motion_verdict_t verdict;
        int unsigned     bg;
        int unsigned     var_next;
        int unsigned     diff;
        int unsigned     target;
        if (first)
        begin
            background_est[idx] = pix;
            variance_est[idx]   = vmin_cfg;
        end
        bg = background_est[idx];
        if (bg < pix)
            bg++;
        else if (bg > pix)
            bg--;
        background_est[idx] = bg[sdmd_pkg::PIX_W-1:0];
        diff = (bg > pix) ? bg - pix : pix - bg;
        target = amp_cfg * diff;
        // The variance step is taken in a wide integer so 255 can step to 256.
        var_next = variance_est[idx];
        if (var_next < target)
            var_next++;
        else if (var_next > target)
            var_next--;
        if (var_next > vmax_cfg)
            var_next = vmax_cfg;
        if (var_next < vmin_cfg)
            var_next = vmin_cfg;
        variance_est[idx] = var_next[sdmd_pkg::VAR_W-1:0];
        verdict.foreground     = (diff >= var_next);
        verdict.abs_difference = diff[sdmd_pkg::PIX_W-1:0];
        verdict.variance       = var_next[sdmd_pkg::VAR_W-1:0];
        return verdict;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 19);
        if (roll < 12)
            return 0;
        if (roll < 18)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Input-side transfers feed the predictor; output-side transfers are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
            begin
                expected_verdicts.push_back(update_motion(pixel_value, pixel_index,
                                                          first_frame));
                pixels_in_flight--;
                pixel_sent = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 32'(variance_out),
                                    32'd0);
                end
                else
                begin
                    oldest_verdict = expected_verdicts.pop_front();
                    if (foreground !== oldest_verdict.foreground)
                        report_mismatch("foreground", 32'(foreground),
                                        32'(oldest_verdict.foreground));
                    if (abs_difference !== oldest_verdict.abs_difference)
                        report_mismatch("abs_difference", 32'(abs_difference),
                                        32'(oldest_verdict.abs_difference));
                    if (variance_out !== oldest_verdict.variance)
                        report_mismatch("variance_out", 32'(variance_out),
                                        32'(oldest_verdict.variance));
                end
            end
        end
    end

    // Pixel driver: holds each item until its transfer, then waits out a gap.
    always @(negedge clk)
    begin
        if (rst_n && (!pixel_valid || pixel_sent))
        begin
            pixel_sent = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                pixel_valid <= 1'b0;
            end
            else if (pixel_queue.size() > 0)
            begin
                pixel_valid <= 1'b1;
                pixel_value <= pixel_queue[0].value;
                pixel_index <= pixel_queue[0].index;
                first_frame <= pixel_queue[0].first;
                void'(pixel_queue.pop_front());
                send_gap = pick_gap();
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls; a long hold-off overrides it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_result)
            begin
                result_ready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                ready_gap = pick_gap();
            end
        end
    end

    initial
    begin : receiver_holdoff
        wait (hold_trigger);
        @(negedge clk);
        hold_result = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_result = 1'b0;
    end

    task automatic apb_access(input logic is_write, input sdmd_pkg::reg_index_t which,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {which, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input sdmd_pkg::reg_index_t which);
        logic [31:0] readback;
        logic [31:0] want;
        logic [31:0] mask;
        apb_access(1'b0, which, '0, readback);
        unique case (which)
            sdmd_pkg::REG_AMPLIFICATION:
            begin
                want = 32'(amp_cfg);
                mask = 32'h0000_000F;
            end
            sdmd_pkg::REG_VARIANCE_MIN:
            begin
                want = 32'(vmin_cfg);
                mask = 32'h0000_00FF;
            end
            default:
            begin
                want = 32'(vmax_cfg);
                mask = 32'h0000_00FF;
            end
        endcase
        if ((readback & mask) !== want)
            report_mismatch("register readback", readback, want);
    endtask

    task automatic write_register(input sdmd_pkg::reg_index_t which,
                                  input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, which, value, unused);
        unique case (which)
            sdmd_pkg::REG_AMPLIFICATION: amp_cfg  = value[sdmd_pkg::AMP_W-1:0];
            sdmd_pkg::REG_VARIANCE_MIN:  vmin_cfg = value[sdmd_pkg::VAR_W-1:0];
            default:                     vmax_cfg = value[sdmd_pkg::VAR_W-1:0];
        endcase
        check_register(which);
    endtask

    task automatic set_detector(input int unsigned amp, input int unsigned vmin,
                                input int unsigned vmax);
        write_register(sdmd_pkg::REG_AMPLIFICATION, amp);
        write_register(sdmd_pkg::REG_VARIANCE_MIN, vmin);
        write_register(sdmd_pkg::REG_VARIANCE_MAX, vmax);
    endtask

    task automatic queue_pixel(input int unsigned value, input int unsigned index,
                               input bit first);
        pixel_item_t item;
        item.value = value[sdmd_pkg::PIX_W-1:0];
        item.index = index[sdmd_pkg::INDEX_W-1:0];
        item.first = first;
        if (first && !index_loaded[item.index])
        begin
            index_loaded[item.index] = 1'b1;
            loaded_list.push_back(item.index);
        end
        pixels_in_flight++;
        pixel_queue.push_back(item);
    endtask

    // Waits until every queued pixel has been taken and every result checked.
    task automatic wait_until_idle();
        wait (pixels_in_flight == 0 && expected_verdicts.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    // Mostly a small pool of pixels watching a noisy scene with passing objects,
    // so the estimates evolve; the rest loads or revisits pixels anywhere.
    task automatic queue_scene(input int unsigned count);
        int unsigned n;
        int unsigned roll;
        int unsigned slot;
        int          level;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
            begin
                slot = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 9) == 0)
                    scene_level[slot] = $urandom_range(0, 255);
                level = scene_level[slot] + int'($urandom_range(0, 6)) - 3;
                if (level < 0)
                    level = 0;
                if (level > 255)
                    level = 255;
                queue_pixel(level, hot_index[slot],
                            !index_loaded[hot_index[slot]] || $urandom_range(0, 19) == 0);
            end
            else if (roll < 92)
            begin
                queue_pixel($urandom_range(0, 255), $urandom_range(0, 65535), 1'b1);
            end
            else
            begin
                queue_pixel($urandom_range(0, 255),
                            loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                            $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial
    begin : stimulus
        int unsigned phase_amp [RANDOM_PHASES]  = '{1, 15, 2, 15, 0, 8, 3, 1};
        int unsigned phase_vmin [RANDOM_PHASES] = '{0, 0, 1, 255, 5, 0, 10, 0};
        int unsigned phase_vmax [RANDOM_PHASES] = '{255, 255, 254, 0, 30, 255, 40, 0};
        int unsigned phase;
        int unsigned slot;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pixel_valid  = 1'b0;
        pixel_value  = '0;
        pixel_index  = '0;
        first_frame  = 1'b0;
        result_ready = 1'b0;
        for (slot = 0; slot < POOL_SIZE; slot++)
        begin
            hot_index[slot]   = $urandom_range(0, 65535);
            scene_level[slot] = $urandom_range(0, 255);
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Reset values of the registers, then the extremes of every field.
        check_register(sdmd_pkg::REG_AMPLIFICATION);
        check_register(sdmd_pkg::REG_VARIANCE_MIN);
        check_register(sdmd_pkg::REG_VARIANCE_MAX);
        queue_pixel(0, 0, 1'b1);
        queue_pixel(255, 16'hFFFF, 1'b1);
        queue_pixel(255, 0, 1'b0);
        queue_pixel(255, 0, 1'b0);
        queue_pixel(0, 16'hFFFF, 1'b0);
        queue_pixel(128, 0, 1'b1);
        queue_pixel(8'hAA, 16'h5555, 1'b1);
        queue_pixel(8'h55, 16'hAAAA, 1'b1);
        wait_until_idle();

        // Variance parked at 255, then stepped upward with the upper bound at 255:
        // it must saturate rather than wrap.
        set_detector(15, 255, 255);
        queue_pixel(0, 16'h1234, 1'b1);
        wait_until_idle();
        set_detector(15, 0, 255);
        queue_pixel(255, 16'h1234, 1'b0);
        queue_pixel(255, 16'h1234, 1'b0);
        wait_until_idle();

        // Zero amplification pulls the variance down toward zero.
        set_detector(0, 0, 254);
        queue_pixel(255, 16'h1234, 1'b0);
        queue_pixel(255, 16'h1234, 1'b0);
        queue_pixel(255, 16'h1234, 1'b0);
        queue_pixel(128, 0, 1'b0);
        wait_until_idle();

        // Lower bound above the upper bound: the lower bound wins.
        set_detector(4, 200, 10);
        queue_pixel(0, 16'h1234, 1'b0);
        queue_pixel(0, 0, 1'b0);
        queue_pixel(77, 1, 1'b1);
        wait_until_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES - 1)
                set_detector($urandom_range(0, 15), $urandom_range(0, 255),
                             $urandom_range(0, 255));
            else
                set_detector(phase_amp[phase], phase_vmin[phase], phase_vmax[phase]);
            idle_on = (phase % 3 != 2);
            if (phase == 1)
                hold_trigger = 1'b1;
            queue_scene(PHASE_ITEMS);
            wait_until_idle();
        end

        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
